@@ rtl/dfsme_pkg.sv @@
// Shared types and constants for the depth-first maze explorer step block.
// No dependencies; imported by the top level dfs_maze_explorer_step.
package dfsme_pkg;

	localparam int COORD_BITS   = 6;
	localparam int CELL_BITS    = 2 * COORD_BITS;
	localparam int CELL_COUNT   = 1 << CELL_BITS;
	localparam int DEPTH_BITS   = CELL_BITS + 1;
	localparam int TILE_BITS    = 8;
	localparam int IN_BITS      = CELL_BITS + 4 * TILE_BITS;
	localparam int S_DATA_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int MOVE_BITS    = 3;
	localparam int OUT_BITS     = MOVE_BITS + 1;
	localparam int M_DATA_W     = ((OUT_BITS + 7) / 8) * 8;
	localparam int REG_IDX_BITS = 2;
	localparam int REG_BITS     = 8;

	localparam logic [REG_IDX_BITS-1:0] REG_FLOOR = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_GOAL  = REG_IDX_BITS'(1);

	// Neighbor order used for the visited-map lookups
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CELL_BITS-1:0]  cell_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef enum logic [MOVE_BITS-1:0] {
		MOVE_NONE  = 3'd0,
		MOVE_UP    = 3'd1,
		MOVE_RIGHT = 3'd2,
		MOVE_DOWN  = 3'd3,
		MOVE_LEFT  = 3'd4
	} move_t;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic  ok;
		cell_t addr;
	} nbr_t;

	// Map address of a neighbor and whether it lies inside the grid
	function automatic nbr_t nbr_at(coord_t x, coord_t y, logic [1:0] dir);
		nbr_t n;
		unique case (dir)
			DIR_UP: begin
				n.addr = {coord_t'(y + 1'b1), x};
				n.ok   = (y != '1);
			end
			DIR_RIGHT: begin
				n.addr = {y, coord_t'(x - 1'b1)};
				n.ok   = (x != '0);
			end
			DIR_DOWN: begin
				n.addr = {coord_t'(y - 1'b1), x};
				n.ok   = (y != '0);
			end
			default: begin
				n.addr = {y, coord_t'(x + 1'b1)};
				n.ok   = (x != '1);
			end
		endcase
		return n;
	endfunction

endpackage

@@ rtl/dfsme_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the visited map and the path stack.
module dfsme_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/dfs_maze_explorer_step.sv @@
// Channel  | Dir | Fields (low bit first)                                   | Handshake
// s_axis   | in  | pos_x, pos_y, tile_up, tile_right, tile_down, tile_left  | tvalid/tready
// m_axis   | out | move, stack_overflow                                     | tvalid/tready
// cfg      | in  | register index, data (0 floor_code, 1 goal_code)         | cfg_we only
//
// Each item is accepted, then steps through the read and finish states, paced by the
// single read port of the visited map serving the four neighbor lookups.
// After reset a clearing pass writes all 4096 visited-map entries, one per cycle,
// with s_tready low; configuration writes are taken throughout.
// A result waits in the output register; the next item is accepted meanwhile and
// its last cycle stalls until the register is free.
// Depends on dfsme_pkg and dfsme_ram.
module dfs_maze_explorer_step
	import dfsme_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// pos_x, pos_y, tile_up, tile_right, tile_down, tile_left, zero fill
	input  logic [S_DATA_W-1:0]     s_tdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// move, stack_overflow, zero fill
	output logic [M_DATA_W-1:0]     m_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]     cfg_data
);

	state_t state_q, state_d;
	cell_t  clr_q;
	logic [1:0] k_q;
	coord_t x_q, y_q;
	logic [3:0] walk_q;
	logic [2:0] open_q;
	depth_t depth_q;
	logic [REG_BITS-1:0] floor_q, goal_q;
	logic   m_tvalid_q;
	move_t  move_q;
	logic   ovf_q;

	logic   accept, out_free, fin_go;
	coord_t in_x, in_y;
	logic [3:0] in_walk;
	logic   vis_we, vis_wdata, vis_re, vis_rdata;
	cell_t  vis_waddr, vis_raddr;
	logic   st_we, st_re;
	cell_t  st_waddr, st_raddr, st_wdata, st_rdata;
	nbr_t   nbr_first, nbr_cur, nbr_last, nbr_prev;
	logic [1:0] k_prev;
	logic   open_last;
	logic [3:0] cand;
	move_t  pick, move_d;
	logic   push, full, ovf_d, pop;
	logic [COORD_BITS:0] px_e, py_e, cx_e, cy_e;

	assign in_x = s_tdata[COORD_BITS-1:0];
	assign in_y = s_tdata[CELL_BITS-1:COORD_BITS];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			in_walk[i] = (s_tdata[CELL_BITS + i*TILE_BITS +: TILE_BITS] == floor_q) ||
				(s_tdata[CELL_BITS + i*TILE_BITS +: TILE_BITS] == goal_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	// Visited map: clearing pass, mark on accept, neighbor reads
	assign nbr_first = nbr_at(in_x, in_y, DIR_UP);
	assign nbr_cur   = nbr_at(x_q, y_q, k_q);
	assign nbr_last  = nbr_at(x_q, y_q, DIR_LEFT);
	assign k_prev    = k_q - 2'd1;
	assign nbr_prev  = nbr_at(x_q, y_q, k_prev);

	assign vis_we    = (state_q == ST_CLR) || accept;
	assign vis_waddr = (state_q == ST_CLR) ? clr_q : {in_y, in_x};
	assign vis_wdata = (state_q != ST_CLR);
	assign vis_re    = accept || (state_q == ST_RD);
	assign vis_raddr = accept ? nbr_first.addr : nbr_cur.addr;

	dfsme_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (vis_re),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	// Path stack: top entry read on accept, held until the finish cycle
	assign st_re    = accept;
	assign st_raddr = cell_t'(depth_q[CELL_BITS-1:0] - 1'b1);
	assign st_waddr = depth_q[CELL_BITS-1:0];
	assign st_wdata = {y_q, x_q};
	assign st_we    = fin_go && push && !full;

	dfsme_ram #(.WIDTH(CELL_BITS), .DEPTH(CELL_COUNT)) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Decision in the finish cycle
	assign open_last = !nbr_last.ok || !vis_rdata;
	assign cand      = walk_q & {open_last, open_q};
	assign full      = depth_q[CELL_BITS];

	always_comb begin
		px_e = {1'b0, st_rdata[COORD_BITS-1:0]};
		py_e = {1'b0, st_rdata[CELL_BITS-1:COORD_BITS]};
		cx_e = {1'b0, x_q};
		cy_e = {1'b0, y_q};

		priority if (cand[0]) pick = MOVE_UP;
		else if (cand[1])     pick = MOVE_RIGHT;
		else if (cand[2])     pick = MOVE_DOWN;
		else if (cand[3])     pick = MOVE_LEFT;
		else                  pick = MOVE_NONE;

		push  = (pick != MOVE_NONE);
		pop   = !push && (depth_q != '0);
		ovf_d = push && full;
		move_d = pick;
		if (pop) begin
			// exact compares: no wrap at the grid edge
			priority if (py_e == cy_e + 1'b1) move_d = MOVE_UP;
			else if (px_e + 1'b1 == cx_e)     move_d = MOVE_RIGHT;
			else if (py_e + 1'b1 == cy_e)     move_d = MOVE_DOWN;
			else if (px_e == cx_e + 1'b1)     move_d = MOVE_LEFT;
			else                              move_d = MOVE_NONE;
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = ST_RD;
			ST_RD:   if (k_q == DIR_LEFT) state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			k_q        <= DIR_UP;
			depth_q    <= '0;
			floor_q    <= '0;
			goal_q     <= REG_BITS'(1);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				k_q <= DIR_RIGHT;
			end else if (state_q == ST_RD) begin
				k_q <= k_q + 2'd1;
			end
			if (fin_go) begin
				if (push && !full) begin
					depth_q <= depth_q + 1'b1;
				end else if (pop) begin
					depth_q <= depth_q - 1'b1;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FLOOR: floor_q <= cfg_data;
					REG_GOAL:  goal_q  <= cfg_data;
					default: ;
				endcase
			end
			if (fin_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_x;
			y_q    <= in_y;
			walk_q <= in_walk;
		end
		if (state_q == ST_RD) begin
			open_q[k_prev] <= !nbr_prev.ok || !vis_rdata;
		end
		if (fin_go) begin
			move_q <= move_d;
			ovf_q  <= ovf_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_DATA_W - OUT_BITS)'(0), ovf_q, move_q};

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= depth_t'(CELL_COUNT))
		else $error("stack depth beyond capacity");

	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (depth_q == $past(depth_q) || depth_q == $past(depth_q) + 1'b1 ||
			depth_q == $past(depth_q) - 1'b1))
		else $error("stack depth moved by more than one");

	a_ovf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && ovf_d) |=> $stable(depth_q))
		else $error("dropped push changed stack depth");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !fin_go)
		else $error("result overwritten before transaction");

	a_clr_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> (!s_tready && !vis_re))
		else $error("input taken during clearing pass");
`endif

endmodule

@@ test/dfsme_checker.sv @@
// Checker for dfs_maze_explorer_step: watches the input, output and register write ports,
// predicts each step's move and overflow flag, and compares them in order.
// Depends on dfsme_pkg.
`timescale 1ns / 100ps

module dfsme_checker
	import dfsme_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [S_DATA_W-1:0]     s_tdata,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [M_DATA_W-1:0]     m_tdata,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]     cfg_data,
	output int                      errors,
	output int                      pending
);

	localparam int GRID = 1 << COORD_BITS;

	typedef struct {
		move_t mv;
		logic  ovf;
	} decision_t;

	bit                   visited [CELL_COUNT];
	cell_t                trail [CELL_COUNT];
	int unsigned          trail_len;
	logic [REG_BITS-1:0]  floor_code;
	logic [REG_BITS-1:0]  goal_code;
	decision_t            moves_due [$];
	int                   fail_cnt = 0;

	assign errors = fail_cnt;

	function automatic logic [TILE_BITS-1:0] tile_of(logic [S_DATA_W-1:0] item, logic [1:0] dir);
		return item[CELL_BITS + int'(dir) * TILE_BITS +: TILE_BITS];
	endfunction

	function automatic bit tile_passable(logic [TILE_BITS-1:0] code);
		return code == floor_code || code == goal_code;
	endfunction

	// Cells off the grid count as never visited
	function automatic bit is_open(int x, int y);
		if (x < 0 || y < 0 || x >= GRID || y >= GRID)
			return 1'b1;
		return !visited[y * GRID + x];
	endfunction

	function automatic decision_t decide(logic [S_DATA_W-1:0] item);
		int        cx;
		int        cy;
		int        px;
		int        py;
		cell_t     back;
		decision_t d;
		cx = int'(item[0 +: COORD_BITS]);
		cy = int'(item[COORD_BITS +: COORD_BITS]);
		d.mv = MOVE_NONE;
		d.ovf = 1'b0;
		visited[cy * GRID + cx] = 1'b1;
		if (tile_passable(tile_of(item, DIR_UP)) && is_open(cx, cy + 1))
			d.mv = MOVE_UP;
		else if (tile_passable(tile_of(item, DIR_RIGHT)) && is_open(cx - 1, cy))
			d.mv = MOVE_RIGHT;
		else if (tile_passable(tile_of(item, DIR_DOWN)) && is_open(cx, cy - 1))
			d.mv = MOVE_DOWN;
		else if (tile_passable(tile_of(item, DIR_LEFT)) && is_open(cx + 1, cy))
			d.mv = MOVE_LEFT;

		if (d.mv != MOVE_NONE) begin
			if (trail_len < CELL_COUNT) begin
				trail[trail_len] = cell_t'(cy * GRID + cx);
				trail_len++;
			end else begin
				d.ovf = 1'b1;
			end
		end else if (trail_len > 0) begin
			// Step back toward the popped cell; no wrap, first match wins
			trail_len--;
			back = trail[trail_len];
			px = int'(back[0 +: COORD_BITS]);
			py = int'(back[COORD_BITS +: COORD_BITS]);
			if (py == cy + 1)
				d.mv = MOVE_UP;
			else if (px == cx - 1)
				d.mv = MOVE_RIGHT;
			else if (py == cy - 1)
				d.mv = MOVE_DOWN;
			else if (px == cx + 1)
				d.mv = MOVE_LEFT;
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decision_t due;
		if (!arst_n) begin
			for (int i = 0; i < CELL_COUNT; i++)
				visited[i] = 1'b0;
			trail_len = 0;
			floor_code = '0;
			goal_code = REG_BITS'(1);
			moves_due.delete();
			pending <= 0;
		end else begin
			// An item taken on the same edge as a register write still sees the old codes
			if (s_tvalid && s_tready) begin
				due = decide(s_tdata);
				moves_due.insert(moves_due.size(), due);
			end
			if (cfg_we) begin
				if (cfg_index == REG_FLOOR)
					floor_code = cfg_data;
				else if (cfg_index == REG_GOAL)
					goal_code = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (moves_due.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected transaction, move %0d overflow %0b", $time,
						m_tdata[MOVE_BITS-1:0], m_tdata[MOVE_BITS]);
				end else begin
					due = moves_due.pop_front();
					if (m_tdata[MOVE_BITS-1:0] !== due.mv) begin
						fail_cnt++;
						$display("%0t: move expected %0d, actual %0d", $time, due.mv,
							m_tdata[MOVE_BITS-1:0]);
					end
					if (m_tdata[MOVE_BITS] !== due.ovf) begin
						fail_cnt++;
						$display("%0t: stack_overflow expected %0b, actual %0b", $time,
							due.ovf, m_tdata[MOVE_BITS]);
					end
				end
			end
			pending <= moves_due.size();
		end
	end

endmodule

@@ test/tb.sv @@
// Top of the dfs_maze_explorer_step testbench: clock, reset, register writes, step stimulus
// with sender and receiver idling, and the verdict. Depends on dfsme_pkg and dfsme_checker.
`timescale 1ns / 100ps

module tb;
	import dfsme_pkg::*;

	localparam int GRID = 1 << COORD_BITS;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int DRAIN_ITEMS = 32;
	localparam int HOLD_CYCLES = 400;
	// Indexes with no register behind them
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE0 = REG_IDX_BITS'(2);
	localparam logic [REG_IDX_BITS-1:0] REG_SPARE1 = REG_IDX_BITS'(3);

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic [S_DATA_W-1:0]     s_tdata = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [M_DATA_W-1:0]     m_tdata;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [REG_IDX_BITS-1:0] cfg_index = '0;
	logic [REG_BITS-1:0]     cfg_data = '0;
	int                      errors;
	int                      pending;

	int                      send_idle = 0;
	int                      recv_stall = 0;
	int                      hold_req = 0;
	int                      hold_ack = 0;
	int                      hold_left = 0;
	logic [TILE_BITS-1:0]    floor_code = '0;
	logic [TILE_BITS-1:0]    goal_code = TILE_BITS'(1);
	coord_t                  cur_x = '0;
	coord_t                  cur_y = '0;
	cell_t                   path_back [$];

	dfs_maze_explorer_step dut (.*);

	dfsme_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic logic [S_DATA_W-1:0] pack_cell(coord_t x, coord_t y,
		logic [TILE_BITS-1:0] up, logic [TILE_BITS-1:0] rt,
		logic [TILE_BITS-1:0] dn, logic [TILE_BITS-1:0] lf);
		return S_DATA_W'({lf, dn, rt, up, y, x});
	endfunction

	function automatic logic [TILE_BITS-1:0] wall_tile();
		logic [TILE_BITS-1:0] v;
		do
			v = TILE_BITS'($urandom_range(255));
		while (v == floor_code || v == goal_code);
		return v;
	endfunction

	function automatic logic [TILE_BITS-1:0] pick_tile();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return floor_code;
		if (r < 45)
			return goal_code;
		if (r < 85)
			return wall_tile();
		return TILE_BITS'($urandom_range(255));
	endfunction

	task automatic send_item(input logic [S_DATA_W-1:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_cell(input coord_t x, input coord_t y, input logic [TILE_BITS-1:0] up,
		input logic [TILE_BITS-1:0] rt, input logic [TILE_BITS-1:0] dn,
		input logic [TILE_BITS-1:0] lf);
		send_item(pack_cell(x, y, up, rt, dn, lf));
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
		if (idx == REG_FLOOR)
			floor_code = val;
		else if (idx == REG_GOAL)
			goal_code = val;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop the input, wait until every expected result has come, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Forward: open one neighbor and step there. Back: wall in and return along the path.
	task automatic walk_step();
		logic [TILE_BITS-1:0] t [4];
		logic [1:0]           dir;
		if (path_back.size() > 0 && $urandom_range(99) < 35) begin
			for (int k = 0; k < 4; k++)
				t[k] = ($urandom_range(99) < 80) ? wall_tile() : pick_tile();
			send_cell(cur_x, cur_y, t[DIR_UP], t[DIR_RIGHT], t[DIR_DOWN], t[DIR_LEFT]);
			{cur_y, cur_x} = path_back[path_back.size() - 1];
			path_back.delete(path_back.size() - 1);
		end else begin
			dir = 2'($urandom_range(3));
			for (int k = 0; k < 4; k++)
				t[k] = (k < int'(dir) && $urandom_range(99) < 70) ? wall_tile() : pick_tile();
			t[dir] = $urandom_range(1) ? floor_code : goal_code;
			send_cell(cur_x, cur_y, t[DIR_UP], t[DIR_RIGHT], t[DIR_DOWN], t[DIR_LEFT]);
			path_back.insert(path_back.size(), cell_t'({cur_y, cur_x}));
			if (path_back.size() > 200)
				void'(path_back.pop_front());
			case (dir)
				DIR_UP:    cur_y = cur_y + 1'b1;
				DIR_RIGHT: cur_x = cur_x - 1'b1;
				DIR_DOWN:  cur_y = cur_y - 1'b1;
				default:   cur_x = cur_x + 1'b1;
			endcase
		end
	endtask

	task automatic noise_step();
		logic [TILE_BITS-1:0] t [4];
		for (int k = 0; k < 4; k++)
			t[k] = $urandom_range(1) ? pick_tile() : TILE_BITS'($urandom_range(255));
		send_cell(coord_t'($urandom_range(GRID - 1)), coord_t'($urandom_range(GRID - 1)),
			t[DIR_UP], t[DIR_RIGHT], t[DIR_DOWN], t[DIR_LEFT]);
	endtask

	initial begin
		logic [REG_BITS-1:0] same;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset codes: floor 0, goal 1; 2 and 255 act as walls
		send_cell(6'd0, 6'd0, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd0, 6'd0, 8'd255, 8'd0, 8'd255, 8'd255);
		send_cell(6'd0, 6'd0, 8'd2, 8'd2, 8'd1, 8'd2);
		send_cell(6'd63, 6'd63, 8'd0, 8'd2, 8'd2, 8'd2);
		send_cell(6'd63, 6'd63, 8'd2, 8'd2, 8'd2, 8'd0);
		send_cell(6'd10, 6'd10, 8'd0, 8'd2, 8'd2, 8'd2);
		send_cell(6'd10, 6'd11, 8'd0, 8'd2, 8'd2, 8'd2);
		send_cell(6'd10, 6'd12, 8'd2, 8'd2, 8'd0, 8'd2);
		send_cell(6'd10, 6'd11, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd10, 6'd10, 8'd2, 8'd1, 8'd2, 8'd2);
		send_cell(6'd9, 6'd10, 8'd2, 8'd2, 8'd2, 8'd0);
		send_cell(6'd11, 6'd10, 8'd2, 8'd0, 8'd2, 8'd2);
		send_cell(6'd20, 6'd20, 8'd2, 8'd2, 8'd2, 8'd0);
		send_cell(6'd21, 6'd20, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd63, 6'd62, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd0, 6'd63, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd1, 6'd0, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd5, 6'd5, 8'd2, 8'd2, 8'd2, 8'd2);
		send_cell(6'd5, 6'd5, 8'd255, 8'd255, 8'd255, 8'd255);

		for (int p = 0; p < 5; p++) begin
			settle();
			case (p)
				0: begin
					write_reg(REG_FLOOR, 8'h00);
					write_reg(REG_GOAL, 8'hFF);
					send_idle = 0;
					recv_stall <= 0;
				end
				1: begin
					write_reg(REG_FLOOR, 8'hFF);
					write_reg(REG_GOAL, 8'h00);
					send_idle = 75;
					recv_stall <= 0;
				end
				2: begin
					write_reg(REG_FLOOR, 8'hA5);
					write_reg(REG_GOAL, 8'h3C);
					write_reg(REG_SPARE0, 8'h00);
					write_reg(REG_SPARE1, 8'hA5);
					send_idle = 0;
					recv_stall <= 75;
				end
				3: begin
					same = REG_BITS'($urandom_range(255));
					write_reg(REG_FLOOR, same);
					write_reg(REG_GOAL, same);
					send_idle = 10;
					recv_stall <= 10;
				end
				default: begin
					write_reg(REG_FLOOR, REG_BITS'($urandom_range(255)));
					write_reg(REG_GOAL, REG_BITS'($urandom_range(255)));
					send_idle = 0;
					recv_stall <= 0;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Hold the output while items keep coming so the input backs up
				if (p == 0 && i == 30)
					hold_req <= hold_req + 1;
				if (p == 4 && i == ITEMS_PER_PHASE / 2)
					settle();
				if ($urandom_range(99) < 15)
					noise_step();
				else
					walk_step();
			end
		end

		// Walled in everywhere: pop back along the path stack
		settle();
		write_reg(REG_FLOOR, 8'h5A);
		write_reg(REG_GOAL, 8'hC3);
		send_idle = 0;
		recv_stall <= 0;
		repeat (DRAIN_ITEMS)
			send_cell(coord_t'($urandom_range(GRID - 1)), coord_t'($urandom_range(GRID - 1)),
				wall_tile(), wall_tile(), wall_tile(), wall_tile());
		s_tvalid <= 1'b0;

		settle();
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
